### design/nnp_pkg.sv
// Shared types and constants for the network-name element packer.
// No dependencies; every other design file uses this package.
package nnp_pkg;

  localparam int CMD_W      = 1;
  localparam int COUNT_W    = 6;
  localparam int CI_W       = 16;
  localparam int CODE_W     = 8;
  localparam int SEPTET_W   = 7;
  localparam int BYTE_W     = 8;
  localparam int FILL_W     = 3;
  localparam int MAX_BYTES  = 4;
  localparam int NBYTES_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic [CMD_W-1:0] CMD_START = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CHAR  = 1'b1;

  localparam logic ALPHA_GSM7 = 1'b0;
  localparam logic ALPHA_UCS2 = 1'b1;

  localparam logic [BYTE_W-1:0] HDR_BASE = 8'h80;

  // One queue entry: the bytes one transaction produces, in order.
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [NBYTES_W-1:0]               count;  // 1..4
    logic                              fin;    // last byte of entry closes the element
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int k = 0; k < BYTE_W; k++) begin
      r[k] = v[BYTE_W-1-k];
    end
    return r;
  endfunction

endpackage

### design/nnp_in_if.sv
// Input channel of the packer: valid/ready plus the item fields.
// Depends on nnp_pkg for field widths.
interface nnp_in_if;
  logic                           valid;
  logic                           ready;
  logic [nnp_pkg::CMD_W-1:0]      command;
  logic [nnp_pkg::COUNT_W-1:0]    char_count;
  logic                           alphabet;
  logic [nnp_pkg::CI_W-1:0]       ci_value;
  logic [nnp_pkg::CODE_W-1:0]     char_code;

  modport source (output valid, command, char_count, alphabet, ci_value, char_code,
                  input ready);
  modport sink   (input valid, command, char_count, alphabet, ci_value, char_code,
                  output ready);
endinterface

### design/nnp_out_if.sv
// Output channel of the packer: valid/ready plus one encoded byte.
// Depends on nnp_pkg for field widths.
interface nnp_out_if;
  logic                         valid;
  logic                         ready;
  logic [nnp_pkg::BYTE_W-1:0]   out_byte;
  logic                         last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

### design/network_name_ie_packer.sv
// Top level of the network-name element packer: front end, entry queue,
// back end. Uses nnp_pkg, nnp_in_if, nnp_out_if, nnp_front, nnp_queue, nnp_back.
//
//   channel  dir  fields                                          handshake
//   item     in   command char_count alphabet ci_value char_code  valid/ready
//   result   out  out_byte last                                   valid/ready
//
// An item is taken every cycle while the 4-entry queue has room. The output
// port moves one byte a cycle while result.ready is high, so an item that yields
// k bytes holds the back end until all k bytes have left; the queue soaks up
// bursts. Reset is synchronous; item.ready is low while rst is high and rises as
// soon as rst falls. A stalled result holds its byte while the front keeps filling the queue.
module network_name_ie_packer #(
  parameter int MAX_NAME_CHARS = 32
) (
  input  logic       clk,
  input  logic       rst,
  nnp_in_if.sink     item,
  nnp_out_if.source  result
);
  import nnp_pkg::*;

  logic      push;
  logic      pop;
  entry_t    push_entry;
  entry_t    q_head;
  q_status_t q_status;

  nnp_front #(.MAX_NAME_CHARS(MAX_NAME_CHARS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  nnp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (push_entry),
    .pop    (pop),
    .dout   (q_head),
    .status (q_status)
  );

  nnp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_status (q_status),
    .pop      (pop),
    .result   (result)
  );

endmodule

### design/nnp_front.sv
// Front end: accepts items, tracks name state, packs septets and builds
// one queue entry per productive transaction. Uses nnp_pkg, nnp_in_if.
module nnp_front #(
  parameter int MAX_NAME_CHARS = 32
) (
  input  logic             clk,
  input  logic             rst,
  nnp_in_if.sink           item,
  input  nnp_pkg::q_status_t q_status,
  output logic             push,
  output nnp_pkg::entry_t  push_entry
);
  import nnp_pkg::*;

  localparam int CW = $clog2(MAX_NAME_CHARS + 1);
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_NAME_CHARS);

  logic                 ucs2_mode, ucs2_mode_next;
  logic [CI_W-1:0]      ci_store, ci_store_next;
  logic [CW-1:0]        chars_left, chars_left_next;
  logic [BYTE_W-1:0]    bit_accumulator, bit_accumulator_next;
  logic [FILL_W-1:0]    bits_filled, bits_filled_next;

  logic                 accept;
  logic [COUNT_W-1:0]   cnt_sat;
  logic [15:0]          wide;
  logic [4:0]           cand_v;
  logic [4:0][BYTE_W-1:0] cand_b;
  logic                 fin;
  logic [NBYTES_W-1:0]  n;
  logic [MAX_BYTES-1:0][BYTE_W-1:0] packed_bytes;
  logic                 ci_nz_in;
  logic                 ci_nz;

  // no transaction is taken while reset is held
  assign item.ready = !q_status.full && !rst;
  assign accept     = item.valid && item.ready;

  assign cnt_sat  = (item.char_count > MAX_CNT) ? MAX_CNT : item.char_count;
  assign ci_nz_in = (item.ci_value != '0);
  assign ci_nz    = (ci_store != '0);
  assign wide     = {8'h00, bit_accumulator} |
                    ({9'h000, item.char_code[SEPTET_W-1:0]} << bits_filled);

  // Candidate byte slots, in emit order: main0, main1, flush, ci high, ci low.
  always_comb begin
    ucs2_mode_next       = ucs2_mode;
    ci_store_next        = ci_store;
    chars_left_next      = chars_left;
    bit_accumulator_next = bit_accumulator;
    bits_filled_next     = bits_filled;
    cand_v = '0;
    cand_b = '0;
    fin    = 1'b0;
    unique case (item.command)
      CMD_START: begin
        ucs2_mode_next       = item.alphabet;
        ci_store_next        = item.ci_value;
        chars_left_next      = CW'(cnt_sat);
        bit_accumulator_next = '0;
        bits_filled_next     = '0;
        // 8*ceil(7n/8) - 7n reduces to n mod 8
        cand_b[0] = HDR_BASE | {3'b000, item.alphabet, ci_nz_in,
                    (item.alphabet == ALPHA_UCS2) ? 3'b000 : cnt_sat[FILL_W-1:0]};
        cand_v[0] = 1'b1;
        if (cnt_sat == '0) begin
          fin       = 1'b1;
          cand_v[3] = ci_nz_in;
          cand_v[4] = ci_nz_in;
          cand_b[3] = item.ci_value[15:8];
          cand_b[4] = item.ci_value[7:0];
        end
      end
      CMD_CHAR: begin
        if (chars_left != '0) begin
          if (ucs2_mode == ALPHA_UCS2) begin
            cand_v[0] = 1'b1;
            cand_b[0] = 8'h00;
            cand_v[1] = 1'b1;
            cand_b[1] = item.char_code;
          end else if (bits_filled != '0) begin
            cand_v[0] = 1'b1;
            cand_b[0] = flip8(wide[7:0]);
            bit_accumulator_next = wide[15:8];
            bits_filled_next     = bits_filled - 3'd1;
          end else begin
            bit_accumulator_next = wide[7:0];
            bits_filled_next     = 3'd7;
          end
          chars_left_next = chars_left - CW'(1);
          if (chars_left == CW'(1)) begin
            fin       = 1'b1;
            cand_v[2] = (ucs2_mode == ALPHA_GSM7) && (bits_filled_next != '0);
            cand_b[2] = flip8(bit_accumulator_next);
            cand_v[3] = ci_nz;
            cand_v[4] = ci_nz;
            cand_b[3] = ci_store[15:8];
            cand_b[4] = ci_store[7:0];
            bit_accumulator_next = '0;
            bits_filled_next     = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Compact the valid slots to the front of the entry.
  always_comb begin
    n = '0;
    packed_bytes = '0;
    for (int i = 0; i < 5; i++) begin
      if (cand_v[i]) begin
        packed_bytes[n[QPTR_W-1:0]] = cand_b[i];
        n = n + 3'd1;
      end
    end
  end

  assign push             = accept && (n != '0);
  assign push_entry.bytes = packed_bytes;
  assign push_entry.count = n;
  assign push_entry.fin   = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      ucs2_mode       <= 1'b0;
      ci_store        <= '0;
      chars_left      <= '0;
      bit_accumulator <= '0;
      bits_filled     <= '0;
    end else if (accept) begin
      ucs2_mode       <= ucs2_mode_next;
      ci_store        <= ci_store_next;
      chars_left      <= chars_left_next;
      bit_accumulator <= bit_accumulator_next;
      bits_filled     <= bits_filled_next;
    end
  end

endmodule

### design/nnp_queue.sv
// Short entry queue between front and back end.
// Uses nnp_pkg (entry_t, depth constants).
module nnp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  nnp_pkg::entry_t    din,
  input  logic               pop,
  output nnp_pkg::entry_t    dout,
  output nnp_pkg::q_status_t status
);
  import nnp_pkg::*;

  entry_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;

  assign status.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign dout         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

### design/nnp_back.sv
// Back end: takes entries off the queue and streams their bytes, one per
// cycle while result.ready is high, through a registered output. Uses nnp_pkg, nnp_out_if.
module nnp_back (
  input  logic               clk,
  input  logic               rst,
  input  nnp_pkg::entry_t    q_head,
  input  nnp_pkg::q_status_t q_status,
  output logic               pop,
  nnp_out_if.source          result
);
  import nnp_pkg::*;

  entry_t             cur;
  logic               cur_valid;
  logic [QPTR_W-1:0]  pos;
  logic               load;
  logic               last_of;

  assign load    = cur_valid && (!result.valid || result.ready);
  assign last_of = (pos == QPTR_W'(cur.count - NBYTES_W'(1)));
  assign pop     = !q_status.empty && (!cur_valid || (load && last_of));

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      pos       <= '0;
    end else if (load && last_of) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      pos <= pos + QPTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_byte <= cur.bytes[pos];
      result.last     <= cur.fin && last_of;
    end
  end

endmodule

### design/nnp_checker.sv
// Port-level checks on the packer's result stream, bound to the top level.
// Depends on nnp_pkg for widths.
module nnp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [nnp_pkg::BYTE_W-1:0] out_byte,
  input logic                       last
);
  import nnp_pkg::*;

  logic hdr_due;  // next byte out must open a new element

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_due <= 1'b1;
    end else if (out_valid && out_ready) begin
      hdr_due <= last;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && hdr_due |->
      out_byte[7] && (out_byte[6:5] == 2'b00) &&
      (!out_byte[4] || (out_byte[2:0] == 3'b000)))
    else $error("element does not open with a valid header");

endmodule

bind network_name_ie_packer nnp_checker u_nnp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_byte  (result.out_byte),
  .last      (result.last)
);
